/* hw/rtl/brr_pkg.sv */
// Shared types and constants for the BRR ADPCM decoder.
// No dependencies; used by brr_mac and brr_adpcm_decoder_top.
package brr_pkg;

    localparam int DATA_BYTES_PER_BLOCK_DEF = 8;

    localparam int COEF_W   = 17;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;

    // one multiply-accumulate step
    typedef struct packed {
        logic                       load_base;
        logic                       sub;
        logic [ACC_W-1:0]           base;
        logic [COEF_W-1:0]          coef;
        logic signed [SAMPLE_W-1:0] sample;
    } mac_op_t;

    function automatic logic [COEF_W-1:0] coef_k1(input logic [1:0] sel);
        logic [COEF_W-1:0] k;
        unique case (sel)
            2'd0: k = 17'd0;
            2'd1: k = 17'd61440;
            2'd2: k = 17'd124928;
            2'd3: k = 17'd117760;
            default: k = 17'd0;
        endcase
        return k;
    endfunction

    function automatic logic [COEF_W-1:0] coef_k2(input logic [1:0] sel);
        logic [COEF_W-1:0] k;
        unique case (sel)
            2'd0: k = 17'd0;
            2'd1: k = 17'd0;
            2'd2: k = 17'd61440;
            2'd3: k = 17'd53248;
            default: k = 17'd0;
        endcase
        return k;
    endfunction

endpackage

/* hw/rtl/brr_mac.sv */
// Shared multiply-accumulate unit: acc <= (base or acc) +/- coef * sample, mod 2^32.
// Depends on brr_pkg.
module brr_mac
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  brr_pkg::mac_op_t            op,
    output logic [brr_pkg::ACC_W-1:0]   acc
);

    logic [brr_pkg::ACC_W-1:0]   acc_reg;
    logic [brr_pkg::ACC_W-1:0]   acc_next;
    logic [brr_pkg::ACC_W-1:0]   addend;
    logic signed [brr_pkg::COEF_W+brr_pkg::SAMPLE_W:0] prod;
    logic [brr_pkg::ACC_W-1:0]   prod_lo;

    always_comb
    begin
        addend   = op.load_base ? op.base : acc_reg;
        prod     = $signed({1'b0, op.coef}) * op.sample;
        prod_lo  = prod[brr_pkg::ACC_W-1:0];
        acc_next = op.sub ? (addend - prod_lo) : (addend + prod_lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* hw/rtl/brr_adpcm_decoder_top.sv */
// BRR ADPCM decoder top level: byte sequencer, sample history and output register.
// Depends on brr_pkg and brr_mac.
//
// A header byte does not stall the input and gives no transaction on the output.
// For a data byte, each of its two samples needs two passes through the single
// shared multiply-accumulate unit (shifted code plus k1*s1, then minus k2*s2),
// and the S_DONE state then moves the pair into the output register once that
// register is free. in_stall is high while a data byte is being decoded. The
// output register lets a new byte be accepted while a finished pair waits; a
// second pair waits in the sequencer until the output register is free.
module brr_adpcm_decoder_top
#(
    parameter int DATA_BYTES_PER_BLOCK = brr_pkg::DATA_BYTES_PER_BLOCK_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               stream_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] first_sample,
    output logic signed [15:0] second_sample
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_P1A,
        S_P1B,
        S_P2A,
        S_P2B,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         byte_reg, byte_next;
    logic [3:0]         pos_reg, pos_next;
    logic [3:0]         shift_reg, shift_next;
    logic [1:0]         sel_reg, sel_next;
    logic signed [15:0] older_reg, older_next;
    logic signed [15:0] newer_reg, newer_next;
    logic signed [15:0] first_reg, first_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] first_out_reg, first_out_next;
    logic signed [15:0] second_out_reg, second_out_next;

    logic               in_acc;
    logic [3:0]         pos_eff;
    logic [3:0]         nibble;
    logic [15:0]        code_ext;
    logic [15:0]        code_shifted;
    logic               mac_en;
    brr_pkg::mac_op_t   mac_op;
    logic [31:0]        mac_acc;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        nibble       = (state_reg == S_P1A || state_reg == S_P1B) ? byte_reg[3:0]
                                                                   : byte_reg[7:4];
        code_ext     = {{12{nibble[3]}}, nibble};
        code_shifted = code_ext << shift_reg;

        mac_en           = 1'b0;
        mac_op.load_base = (state_reg == S_P1A || state_reg == S_P2A);
        mac_op.sub       = (state_reg == S_P1B || state_reg == S_P2B);
        mac_op.base      = {code_shifted, 16'h0000};
        mac_op.coef      = mac_op.sub ? brr_pkg::coef_k2(sel_reg) : brr_pkg::coef_k1(sel_reg);
        mac_op.sample    = newer_reg;

        unique case (state_reg)
            S_IDLE: mac_en = 1'b0;
            S_P1A:
            begin
                mac_en        = 1'b1;
                mac_op.sample = newer_reg;
            end
            S_P1B:
            begin
                mac_en        = 1'b1;
                mac_op.sample = older_reg;
            end
            S_P2A:
            begin
                mac_en        = 1'b1;
                mac_op.sample = $signed(mac_acc[31:16]);
            end
            S_P2B:
            begin
                mac_en        = 1'b1;
                mac_op.sample = newer_reg;
            end
            S_DONE: mac_en = 1'b0;
            default: mac_en = 1'b0;
        endcase
    end

    brr_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mac_en),
        .op    (mac_op),
        .acc   (mac_acc)
    );

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        sel_next        = sel_reg;
        older_next      = older_reg;
        newer_next      = newer_reg;
        first_next      = first_reg;
        out_valid_next  = out_valid_reg;
        first_out_next  = first_out_reg;
        second_out_next = second_out_reg;
        pos_eff         = stream_start ? 4'd0 : pos_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (stream_start)
                    begin
                        older_next = '0;
                        newer_next = '0;
                    end
                    if (pos_eff == 4'd0)
                    begin
                        shift_next = data_byte[3:0];
                        sel_next   = data_byte[5:4];
                        pos_next   = 4'd1;
                    end
                    else
                    begin
                        byte_next  = data_byte;
                        pos_next   = (pos_eff >= 4'(DATA_BYTES_PER_BLOCK)) ? 4'd0
                                                                         : pos_eff + 4'd1;
                        state_next = S_P1A;
                    end
                end
            end
            S_P1A: state_next = S_P1B;
            S_P1B: state_next = S_P2A;
            S_P2A:
            begin
                first_next = $signed(mac_acc[31:16]);
                state_next = S_P2B;
            end
            S_P2B: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    first_out_next  = first_reg;
                    second_out_next = $signed(mac_acc[31:16]);
                    older_next      = first_reg;
                    newer_next      = $signed(mac_acc[31:16]);
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            shift_reg      <= '0;
            sel_reg        <= '0;
            older_reg      <= '0;
            newer_reg      <= '0;
            out_valid_reg  <= 1'b0;
            first_out_reg  <= '0;
            second_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            sel_reg        <= sel_next;
            older_reg      <= older_next;
            newer_reg      <= newer_next;
            out_valid_reg  <= out_valid_next;
            first_out_reg  <= first_out_next;
            second_out_reg <= second_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        first_reg      <= first_next;
    end

    assign out_valid     = out_valid_reg;
    assign first_sample  = first_out_reg;
    assign second_sample = second_out_reg;

endmodule

/* hw/rtl/brr_checker.sv */
// Port-level checks for brr_adpcm_decoder_top, attached by bind.
// No package dependencies.
module brr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               stream_start,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] first_sample,
    input logic signed [15:0] second_sample
);

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    // held output transaction keeps its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_sample)
                                   && $stable(second_sample))
        else $error("output transaction changed while stalled");

    // a stream start byte is a header: no decode follows
    a_hdr_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && stream_start |=> !in_stall)
        else $error("header transaction stalled the input");

    a_hdr_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && stream_start |=> !$rose(out_valid))
        else $error("header transaction produced an output");

    // a new pair appears only as the decode finishes
    a_out_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("output appeared outside decode completion");

endmodule

bind brr_adpcm_decoder_top brr_checker u_brr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .stream_start  (stream_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .first_sample  (first_sample),
    .second_sample (second_sample)
);
